// ----- hdl/btga_pkg.sv -----
// ----------------------------------------------------------------------------
// btga_pkg
// Shared constants and types for the blocked tile gather address generator.
// ----------------------------------------------------------------------------
package btga_pkg;

    localparam int MAX_DIM_DEF  = 4096;
    localparam int MAX_TILE_DEF = 256;

    localparam int DEST_W     = 25;
    localparam int SRC_W      = 28;
    localparam int DIM_REG_W  = 13;
    localparam int TILE_REG_W = 9;
    localparam int STRIDE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSPOSE  = 3'd0,
        CFG_ROWS       = 3'd1,
        CFG_COLS       = 3'd2,
        CFG_ROW_STRIDE = 3'd3,
        CFG_TILE_ROWS  = 3'd4,
        CFG_TILE_COLS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic in_range;
        logic last;
        logic stride_error;
    } t_flags;

endpackage

// ----- hdl/btga_cfg.sv -----
// ----------------------------------------------------------------------------
// btga_cfg
// Configuration registers, size clamping and leading dimension check.
// ----------------------------------------------------------------------------
module btga_cfg #(
    parameter int MAX_DIM  = btga_pkg::MAX_DIM_DEF,
    parameter int MAX_TILE = btga_pkg::MAX_TILE_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int TSZ_W   = $clog2(MAX_TILE + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [btga_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [btga_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_transpose,
    output logic [DIM_W-1:0]                    o_rows,
    output logic [DIM_W-1:0]                    o_cols,
    output logic [btga_pkg::STRIDE_W-1:0]       o_row_stride,
    output logic [TSZ_W-1:0]                    o_tile_rows,
    output logic [TSZ_W-1:0]                    o_tile_cols,
    output logic                                o_stride_err
);

    localparam int DCW = (DIM_W > btga_pkg::DIM_REG_W) ? DIM_W : btga_pkg::DIM_REG_W;
    localparam int TCW = (TSZ_W > btga_pkg::TILE_REG_W) ? TSZ_W : btga_pkg::TILE_REG_W;
    localparam int SCW = (DIM_W > btga_pkg::STRIDE_W) ? DIM_W : btga_pkg::STRIDE_W;

    logic                                r_transpose;
    logic [btga_pkg::DIM_REG_W-1:0]      r_rows;
    logic [btga_pkg::DIM_REG_W-1:0]      r_cols;
    logic [btga_pkg::STRIDE_W-1:0]       r_row_stride;
    logic [btga_pkg::TILE_REG_W-1:0]     r_tile_rows;
    logic [btga_pkg::TILE_REG_W-1:0]     r_tile_cols;
    logic [DCW-1:0]                      rows_x;
    logic [DCW-1:0]                      cols_x;
    logic [TCW-1:0]                      trows_x;
    logic [TCW-1:0]                      tcols_x;
    logic [DIM_W-1:0]                    need;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose  <= 1'b0;
            r_rows       <= btga_pkg::DIM_REG_W'(1);
            r_cols       <= btga_pkg::DIM_REG_W'(1);
            r_row_stride <= btga_pkg::STRIDE_W'(1);
            r_tile_rows  <= btga_pkg::TILE_REG_W'(1);
            r_tile_cols  <= btga_pkg::TILE_REG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                btga_pkg::CFG_TRANSPOSE:  r_transpose  <= i_cfg_data[0];
                btga_pkg::CFG_ROWS:       r_rows       <= i_cfg_data[btga_pkg::DIM_REG_W-1:0];
                btga_pkg::CFG_COLS:       r_cols       <= i_cfg_data[btga_pkg::DIM_REG_W-1:0];
                btga_pkg::CFG_ROW_STRIDE: r_row_stride <= i_cfg_data[btga_pkg::STRIDE_W-1:0];
                btga_pkg::CFG_TILE_ROWS:  r_tile_rows  <= i_cfg_data[btga_pkg::TILE_REG_W-1:0];
                btga_pkg::CFG_TILE_COLS:  r_tile_cols  <= i_cfg_data[btga_pkg::TILE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_x  = DCW'(r_rows);
    assign cols_x  = DCW'(r_cols);
    assign trows_x = TCW'(r_tile_rows);
    assign tcols_x = TCW'(r_tile_cols);

    always_comb begin
        if (rows_x == '0)                 o_rows = DIM_W'(1);
        else if (rows_x > DCW'(MAX_DIM))  o_rows = DIM_W'(MAX_DIM);
        else                              o_rows = DIM_W'(rows_x);

        if (cols_x == '0)                 o_cols = DIM_W'(1);
        else if (cols_x > DCW'(MAX_DIM))  o_cols = DIM_W'(MAX_DIM);
        else                              o_cols = DIM_W'(cols_x);

        if (trows_x == '0)                   o_tile_rows = TSZ_W'(1);
        else if (trows_x > TCW'(MAX_TILE))   o_tile_rows = TSZ_W'(MAX_TILE);
        else                                 o_tile_rows = TSZ_W'(trows_x);

        if (tcols_x == '0)                   o_tile_cols = TSZ_W'(1);
        else if (tcols_x > TCW'(MAX_TILE))   o_tile_cols = TSZ_W'(MAX_TILE);
        else                                 o_tile_cols = TSZ_W'(tcols_x);
    end

    assign need         = r_transpose ? o_rows : o_cols;
    assign o_stride_err = SCW'(r_row_stride) < SCW'(need);
    assign o_transpose  = r_transpose;
    assign o_row_stride = r_row_stride;

endmodule

// ----- hdl/btga_walker.sv -----
// ----------------------------------------------------------------------------
// btga_walker
// Tile walk counters and position register: one position per accepted step.
// ----------------------------------------------------------------------------
module btga_walker #(
    parameter int MAX_DIM  = btga_pkg::MAX_DIM_DEF,
    parameter int MAX_TILE = btga_pkg::MAX_TILE_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int TSZ_W   = $clog2(MAX_TILE + 1),
    localparam int R_W     = $clog2(MAX_DIM + MAX_TILE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    input  logic [DIM_W-1:0]              i_rows,
    input  logic [DIM_W-1:0]              i_cols,
    input  logic [TSZ_W-1:0]              i_tile_rows,
    input  logic [TSZ_W-1:0]              i_tile_cols,
    input  logic                          i_stride_err,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [R_W-1:0]                o_row,
    output logic [R_W-1:0]                o_col,
    output logic [btga_pkg::DEST_W-1:0]   o_dest,
    output btga_pkg::t_flags              o_flags
);

    localparam int TILE_W = $clog2(MAX_TILE);
    localparam int BASE_W = $clog2(MAX_DIM);

    logic [BASE_W-1:0]            r_row_base, n_row_base;
    logic [BASE_W-1:0]            r_col_base, n_col_base;
    logic [TILE_W-1:0]            r_in_row,   n_in_row;
    logic [TILE_W-1:0]            r_in_col,   n_in_col;
    logic [btga_pkg::DEST_W-1:0]  r_dest_cnt, n_dest_cnt;
    logic                         r_done,     n_done;

    logic                         r_valid;
    logic [R_W-1:0]               r_row,  n_row;
    logic [R_W-1:0]               r_col,  n_col;
    logic [btga_pkg::DEST_W-1:0]  r_dest, n_dest;
    btga_pkg::t_flags             r_flags, n_flags;

    logic [BASE_W-1:0]            cur_row_base;
    logic [BASE_W-1:0]            cur_col_base;
    logic [TILE_W-1:0]            cur_in_row;
    logic [TILE_W-1:0]            cur_in_col;
    logic [btga_pkg::DEST_W-1:0]  cur_dest_cnt;
    logic                         cur_done;
    logic [R_W-1:0]               pos_row;
    logic [R_W-1:0]               pos_col;
    logic [R_W-1:0]               next_row_base;
    logic [R_W-1:0]               next_col_base;
    logic                         end_row;
    logic                         end_tile_row;
    logic                         end_tile_col;
    logic                         end_rows;
    logic                         accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cur_row_base = i_restart ? '0 : r_row_base;
        cur_col_base = i_restart ? '0 : r_col_base;
        cur_in_row   = i_restart ? '0 : r_in_row;
        cur_in_col   = i_restart ? '0 : r_in_col;
        cur_dest_cnt = i_restart ? '0 : r_dest_cnt;
        cur_done     = i_restart ? 1'b0 : r_done;

        pos_row       = R_W'(cur_row_base) + R_W'(cur_in_row);
        pos_col       = R_W'(cur_col_base) + R_W'(cur_in_col);
        next_row_base = R_W'(cur_row_base) + R_W'(i_tile_rows);
        next_col_base = R_W'(cur_col_base) + R_W'(i_tile_cols);

        end_row      = ((TILE_W+1)'(cur_in_col) + (TILE_W+1)'(1)) >= (TILE_W+1)'(i_tile_cols);
        end_tile_row = ((TILE_W+1)'(cur_in_row) + (TILE_W+1)'(1)) >= (TILE_W+1)'(i_tile_rows);
        end_tile_col = next_col_base >= R_W'(i_cols);
        end_rows     = next_row_base >= R_W'(i_rows);

        n_row_base = r_row_base;
        n_col_base = r_col_base;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_dest_cnt = r_dest_cnt;
        n_done     = r_done;

        n_row   = '0;
        n_col   = '0;
        n_dest  = '0;
        n_flags = '0;

        if (i_stride_err) begin
            n_flags.stride_error = 1'b1;
        end else if (cur_done) begin
            n_done = 1'b1;
        end else begin
            n_row            = pos_row;
            n_col            = pos_col;
            n_dest           = cur_dest_cnt;
            n_flags.in_range = (pos_row < R_W'(i_rows)) && (pos_col < R_W'(i_cols));
            n_flags.last     = end_row && end_tile_row && end_tile_col && end_rows;

            n_dest_cnt = cur_dest_cnt + btga_pkg::DEST_W'(1);
            n_row_base = cur_row_base;
            n_col_base = cur_col_base;
            n_in_row   = cur_in_row;
            n_in_col   = cur_in_col;
            n_done     = 1'b0;
            if (!end_row) begin
                n_in_col = cur_in_col + TILE_W'(1);
            end else begin
                n_in_col = '0;
                if (!end_tile_row) begin
                    n_in_row = cur_in_row + TILE_W'(1);
                end else begin
                    n_in_row = '0;
                    if (!end_tile_col) begin
                        n_col_base = next_col_base[BASE_W-1:0];
                    end else begin
                        n_col_base = '0;
                        if (!end_rows) begin
                            n_row_base = next_row_base[BASE_W-1:0];
                        end else begin
                            n_row_base = '0;
                            n_done     = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_base <= '0;
            r_col_base <= '0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_dest_cnt <= '0;
            r_done     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_row_base <= n_row_base;
                r_col_base <= n_col_base;
                r_in_row   <= n_in_row;
                r_in_col   <= n_in_col;
                r_dest_cnt <= n_dest_cnt;
                r_done     <= n_done;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_dest  <= n_dest;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_dest  = r_dest;
    assign o_flags = r_flags;

endmodule

// ----- hdl/btga_addr.sv -----
// ----------------------------------------------------------------------------
// btga_addr
// Source index multiply-add and result register.
// ----------------------------------------------------------------------------
module btga_addr #(
    parameter int MAX_DIM  = btga_pkg::MAX_DIM_DEF,
    parameter int MAX_TILE = btga_pkg::MAX_TILE_DEF,
    localparam int R_W     = $clog2(MAX_DIM + MAX_TILE)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [R_W-1:0]                i_row,
    input  logic [R_W-1:0]                i_col,
    input  logic [btga_pkg::DEST_W-1:0]   i_dest,
    input  btga_pkg::t_flags              i_flags,
    input  logic                          i_transpose,
    input  logic [btga_pkg::STRIDE_W-1:0] i_row_stride,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [btga_pkg::DEST_W-1:0]   o_dest_index,
    output logic [btga_pkg::SRC_W-1:0]    o_source_index,
    output btga_pkg::t_flags              o_flags
);

    localparam int PW = R_W + btga_pkg::STRIDE_W + 1;

    logic                          r_valid;
    logic [btga_pkg::DEST_W-1:0]   r_dest;
    logic [btga_pkg::SRC_W-1:0]    r_src, n_src;
    btga_pkg::t_flags              r_flags;
    logic [R_W-1:0]                mul_a;
    logic [R_W-1:0]                add_b;
    logic [PW-1:0]                 sum;

    assign o_ready = !r_valid || i_ready;

    assign mul_a = i_transpose ? i_col : i_row;
    assign add_b = i_transpose ? i_row : i_col;
    assign sum   = PW'(mul_a) * PW'(i_row_stride) + PW'(add_b);
    assign n_src = i_flags.in_range ? btga_pkg::SRC_W'(sum) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_dest  <= i_dest;
            r_src   <= n_src;
            r_flags <= i_flags;
        end
    end

    assign o_valid        = r_valid;
    assign o_dest_index   = r_dest;
    assign o_source_index = r_src;
    assign o_flags        = r_flags;

endmodule

// ----- hdl/blocked_tile_gather_addresses.sv -----
// ----------------------------------------------------------------------------
// blocked_tile_gather_addresses
// Address generator for copying a row-major matrix into a tiled buffer.
//
// Each transaction on the input channel (i_in_valid/o_in_ready) carries one
// restart bit and yields exactly one result transaction on the output channel
// (o_out_valid/i_out_ready): destination index, source index, in-range,
// last and stride-error flags. Restart 1 begins the walk at the first
// position; restart 0 gives the current position and advances, unless the
// walk has ended or the stride is too short. The walk counters and position
// register form the first stage, the source multiply-add and result register
// the second. Throughput is one transaction per cycle while the receiver
// does not stall; when it stalls, the two stages fill, o_in_ready falls and
// no result is dropped. Reset clears the walk to the first position, empties
// the pipeline and loads the registers with transpose 0 and all sizes 1. The
// configuration channel (i_cfg_valid/o_cfg_ready) is always ready; the user
// must write it only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module blocked_tile_gather_addresses #(
    parameter int MAX_DIM  = btga_pkg::MAX_DIM_DEF,
    parameter int MAX_TILE = btga_pkg::MAX_TILE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btga_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btga_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [btga_pkg::DEST_W-1:0]     o_dest_index,
    output logic [btga_pkg::SRC_W-1:0]      o_source_index,
    output logic                            o_in_range,
    output logic                            o_last,
    output logic                            o_stride_error
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int TSZ_W = $clog2(MAX_TILE + 1);
    localparam int R_W   = $clog2(MAX_DIM + MAX_TILE);

    logic                           transpose;
    logic [DIM_W-1:0]               rows;
    logic [DIM_W-1:0]               cols;
    logic [btga_pkg::STRIDE_W-1:0]  row_stride;
    logic [TSZ_W-1:0]               tile_rows;
    logic [TSZ_W-1:0]               tile_cols;
    logic                           stride_err;

    logic                           pos_valid;
    logic                           pos_ready;
    logic [R_W-1:0]                 pos_row;
    logic [R_W-1:0]                 pos_col;
    logic [btga_pkg::DEST_W-1:0]    pos_dest;
    btga_pkg::t_flags               pos_flags;
    btga_pkg::t_flags               out_flags;

    btga_cfg #(
        .MAX_DIM  (MAX_DIM),
        .MAX_TILE (MAX_TILE)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_transpose  (transpose),
        .o_rows       (rows),
        .o_cols       (cols),
        .o_row_stride (row_stride),
        .o_tile_rows  (tile_rows),
        .o_tile_cols  (tile_cols),
        .o_stride_err (stride_err)
    );

    btga_walker #(
        .MAX_DIM  (MAX_DIM),
        .MAX_TILE (MAX_TILE)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_restart    (i_restart),
        .i_rows       (rows),
        .i_cols       (cols),
        .i_tile_rows  (tile_rows),
        .i_tile_cols  (tile_cols),
        .i_stride_err (stride_err),
        .o_valid      (pos_valid),
        .i_ready      (pos_ready),
        .o_row        (pos_row),
        .o_col        (pos_col),
        .o_dest       (pos_dest),
        .o_flags      (pos_flags)
    );

    btga_addr #(
        .MAX_DIM  (MAX_DIM),
        .MAX_TILE (MAX_TILE)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (pos_valid),
        .o_ready        (pos_ready),
        .i_row          (pos_row),
        .i_col          (pos_col),
        .i_dest         (pos_dest),
        .i_flags        (pos_flags),
        .i_transpose    (transpose),
        .i_row_stride   (row_stride),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_dest_index   (o_dest_index),
        .o_source_index (o_source_index),
        .o_flags        (out_flags)
    );

    assign o_in_range     = out_flags.in_range;
    assign o_last         = out_flags.last;
    assign o_stride_error = out_flags.stride_error;

endmodule

// ----- test/tb_blocked_tile_gather_addresses.sv -----
// ----------------------------------------------------------------------------
// tb_blocked_tile_gather_addresses
// Self-checking bench for the blocked tile gather address generator. A table
// of directed transactions covers reset values, size clamping, stride errors,
// padding and the end of the walk. Randomized phases then follow, each with
// its own register setting and its own source/sink throttling. Every result
// transaction is compared, field by field, against its table entry or an
// in-bench predictor. Three phases hold the sink off to back up the input.
// ----------------------------------------------------------------------------
module tb_blocked_tile_gather_addresses;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES  = 16;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PCT [4] = '{0, 59, 0, 36};
    localparam int STALL_PCT [4] = '{0, 0, 59, 36};

    localparam logic [btga_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [btga_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [btga_pkg::DEST_W-1:0] dest;
        logic [btga_pkg::SRC_W-1:0]  source;
        logic                        in_range;
        logic                        last;
        logic                        stride_error;
    } t_gather_addr;

    typedef struct packed {
        logic                            is_reg;
        logic [btga_pkg::CFG_IDX_W-1:0]  idx;
        logic [btga_pkg::CFG_DATA_W-1:0] data;
        logic                            restart;
        logic                            typed;
        t_gather_addr                    want;
    } t_dir_row;

    localparam t_gather_addr ADDR_NONE       = '0;
    localparam t_gather_addr ADDR_FIRST_LAST = '{'0, '0, 1'b1, 1'b1, 1'b0};
    localparam t_gather_addr ADDR_FIRST      = '{'0, '0, 1'b1, 1'b0, 1'b0};
    localparam t_gather_addr ADDR_STRIDE_ERR = '{'0, '0, 1'b0, 1'b0, 1'b1};

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [btga_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [btga_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_restart = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [btga_pkg::DEST_W-1:0]     o_dest_index;
    logic [btga_pkg::SRC_W-1:0]      o_source_index;
    logic                            o_in_range;
    logic                            o_last;
    logic                            o_stride_error;

    // predictor copy of the registers, at their reset values
    logic                            cfg_transpose = 1'b0;
    logic [btga_pkg::DIM_REG_W-1:0]  cfg_rows = btga_pkg::DIM_REG_W'(1);
    logic [btga_pkg::DIM_REG_W-1:0]  cfg_cols = btga_pkg::DIM_REG_W'(1);
    logic [btga_pkg::STRIDE_W-1:0]   cfg_stride = btga_pkg::STRIDE_W'(1);
    logic [btga_pkg::TILE_REG_W-1:0] cfg_tile_rows = btga_pkg::TILE_REG_W'(1);
    logic [btga_pkg::TILE_REG_W-1:0] cfg_tile_cols = btga_pkg::TILE_REG_W'(1);

    // predictor copy of the walk counters
    logic [btga_pkg::DIM_REG_W-1:0]  row_base = '0;
    logic [btga_pkg::DIM_REG_W-1:0]  col_base = '0;
    logic [7:0]                      sub_row = '0;
    logic [7:0]                      sub_col = '0;
    logic [btga_pkg::DEST_W-1:0]     dest_count = '0;
    logic                            walk_finished = 1'b0;

    t_gather_addr pending_addrs [$];
    t_dir_row     dir_table [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           hold_seq = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    blocked_tile_gather_addresses dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_dest_index   (o_dest_index),
        .o_source_index (o_source_index),
        .o_in_range     (o_in_range),
        .o_last         (o_last),
        .o_stride_error (o_stride_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void store_reg(input logic [btga_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [btga_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            btga_pkg::CFG_TRANSPOSE:  cfg_transpose = data[0];
            btga_pkg::CFG_ROWS:       cfg_rows = data[btga_pkg::DIM_REG_W-1:0];
            btga_pkg::CFG_COLS:       cfg_cols = data[btga_pkg::DIM_REG_W-1:0];
            btga_pkg::CFG_ROW_STRIDE: cfg_stride = data[btga_pkg::STRIDE_W-1:0];
            btga_pkg::CFG_TILE_ROWS:  cfg_tile_rows = data[btga_pkg::TILE_REG_W-1:0];
            btga_pkg::CFG_TILE_COLS:  cfg_tile_cols = data[btga_pkg::TILE_REG_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_gather_addr next_gather_addr(input logic restart);
        int unsigned  m, n, tr, tc, need, r, c;
        logic         end_row, end_trow, end_tcol;
        logic [63:0]  src_full;
        t_gather_addr a;
        m = eff_size(cfg_rows, btga_pkg::MAX_DIM_DEF);
        n = eff_size(cfg_cols, btga_pkg::MAX_DIM_DEF);
        tr = eff_size(cfg_tile_rows, btga_pkg::MAX_TILE_DEF);
        tc = eff_size(cfg_tile_cols, btga_pkg::MAX_TILE_DEF);
        need = cfg_transpose ? m : n;
        a = '0;
        if (cfg_stride < need) begin
            a.stride_error = 1'b1;
            return a;
        end
        if (restart) begin
            row_base = '0;
            col_base = '0;
            sub_row = '0;
            sub_col = '0;
            dest_count = '0;
            walk_finished = 1'b0;
        end
        if (walk_finished)
            return a;
        r = row_base + sub_row;
        c = col_base + sub_col;
        a.in_range = (r < m) && (c < n);
        end_row = (sub_col + 1 >= tc);
        end_trow = (sub_row + 1 >= tr);
        end_tcol = (col_base + tc >= n);
        a.last = end_row && end_trow && end_tcol && (row_base + tr >= m);
        a.dest = dest_count;
        if (a.in_range) begin
            src_full = cfg_transpose ? 64'(c) * cfg_stride + r : 64'(r) * cfg_stride + c;
            a.source = src_full[btga_pkg::SRC_W-1:0];
        end
        dest_count = dest_count + 1'b1;
        if (!end_row) begin
            sub_col = sub_col + 1'b1;
        end else begin
            sub_col = '0;
            if (!end_trow) begin
                sub_row = sub_row + 1'b1;
            end else begin
                sub_row = '0;
                if (!end_tcol) begin
                    col_base = btga_pkg::DIM_REG_W'(col_base + tc);
                end else begin
                    col_base = '0;
                    if (row_base + tr < m) begin
                        row_base = btga_pkg::DIM_REG_W'(row_base + tr);
                    end else begin
                        row_base = '0;
                        walk_finished = 1'b1;
                    end
                end
            end
        end
        return a;
    endfunction

    function automatic t_dir_row reg_row(input logic [btga_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [btga_pkg::CFG_DATA_W-1:0] data);
        return '{1'b1, idx, data, 1'b0, 1'b0, ADDR_NONE};
    endfunction

    function automatic t_dir_row item_row(input logic restart);
        return '{1'b0, '0, '0, restart, 1'b0, ADDR_NONE};
    endfunction

    function automatic t_dir_row known_row(input logic restart, input t_gather_addr want);
        return '{1'b0, '0, '0, restart, 1'b1, want};
    endfunction

    // drop input valid and drain the pipeline
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [btga_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btga_pkg::CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        store_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic restart, input logic typed,
                             input t_gather_addr want);
        t_gather_addr pred;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = next_gather_addr(restart);
        pending_addrs.push_back(typed ? want : pred);
    endtask

    always @(posedge i_clk) begin : drain
        t_gather_addr want;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_addrs.size() == 0) begin
                $error("result transaction with nothing expected: dest %0d", o_dest_index);
                mismatch_count++;
            end else begin
                want = pending_addrs.pop_front();
                if (o_dest_index !== want.dest) begin
                    $error("dest_index: expected %0d, got %0d", want.dest, o_dest_index);
                    mismatch_count++;
                end
                if (o_source_index !== want.source) begin
                    $error("source_index: expected %0d, got %0d", want.source,
                           o_source_index);
                    mismatch_count++;
                end
                if (o_in_range !== want.in_range) begin
                    $error("in_range: expected %0b, got %0b", want.in_range, o_in_range);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatch_count++;
                end
                if (o_stride_error !== want.stride_error) begin
                    $error("stride_error: expected %0b, got %0b", want.stride_error,
                           o_stride_error);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : stimulus
        t_dir_row    row;
        int          n_items;
        int unsigned m, n, need, pick;
        logic        transpose, restart;
        logic [btga_pkg::CFG_DATA_W-1:0] rows_val, cols_val, stride_val, trows_val, tcols_val;

        dir_table = '{
            known_row(1'b0, ADDR_FIRST_LAST),
            known_row(1'b0, ADDR_NONE),
            known_row(1'b1, ADDR_FIRST_LAST),
            known_row(1'b0, ADDR_NONE),
            reg_row(btga_pkg::CFG_COLS, 16'd3),
            known_row(1'b0, ADDR_STRIDE_ERR),
            known_row(1'b1, ADDR_STRIDE_ERR),
            reg_row(btga_pkg::CFG_ROW_STRIDE, 16'hFFFF),
            reg_row(btga_pkg::CFG_ROWS, 16'd0),
            reg_row(btga_pkg::CFG_COLS, 16'hFFFF),
            reg_row(btga_pkg::CFG_TILE_ROWS, 16'd0),
            reg_row(btga_pkg::CFG_TILE_COLS, 16'hFFFF),
            reg_row(CFG_SPARE_A, 16'hFFFF),
            reg_row(CFG_SPARE_B, 16'h5A5A),
            known_row(1'b1, ADDR_FIRST),
            item_row(1'b0),
            item_row(1'b0),
            reg_row(btga_pkg::CFG_TRANSPOSE, 16'd1),
            item_row(1'b0),
            item_row(1'b0),
            reg_row(btga_pkg::CFG_ROW_STRIDE, 16'd1),
            item_row(1'b0),
            reg_row(btga_pkg::CFG_ROWS, 16'd5),
            known_row(1'b0, ADDR_STRIDE_ERR),
            reg_row(btga_pkg::CFG_TRANSPOSE, 16'd0),
            reg_row(btga_pkg::CFG_ROWS, 16'd3),
            reg_row(btga_pkg::CFG_COLS, 16'd3),
            reg_row(btga_pkg::CFG_ROW_STRIDE, 16'd3),
            reg_row(btga_pkg::CFG_TILE_ROWS, 16'd2),
            reg_row(btga_pkg::CFG_TILE_COLS, 16'd2),
            known_row(1'b1, ADDR_FIRST),
            item_row(1'b0), item_row(1'b0), item_row(1'b0), item_row(1'b0),
            item_row(1'b0), item_row(1'b0), item_row(1'b0), item_row(1'b0),
            item_row(1'b0), item_row(1'b0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[k]) begin
            row = dir_table[k];
            if (row.is_reg)
                write_reg(row.idx, row.data);
            else
                send_item(row.restart, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            gap_pct = GAP_PCT[p % 4];
            stall_pct = STALL_PCT[p % 4];
            transpose = 1'($urandom_range(1));
            if (p % 8 == 5) begin
                rows_val = $urandom_range(1) ? 16'd4096 : 16'($urandom_range(1, 4096));
                cols_val = $urandom_range(1) ? 16'd4096 : 16'($urandom_range(1, 4096));
                trows_val = $urandom_range(1) ? 16'd256 : 16'($urandom_range(1, 256));
                tcols_val = $urandom_range(1) ? 16'd256 : 16'($urandom_range(1, 256));
            end else begin
                rows_val = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                cols_val = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                trows_val = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
                tcols_val = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            end
            m = eff_size(rows_val[btga_pkg::DIM_REG_W-1:0], btga_pkg::MAX_DIM_DEF);
            n = eff_size(cols_val[btga_pkg::DIM_REG_W-1:0], btga_pkg::MAX_DIM_DEF);
            need = transpose ? m : n;
            pick = $urandom_range(99);
            if (pick < 12)
                stride_val = 16'($urandom_range(0, need - 1));
            else if (pick < 20)
                stride_val = 16'hFFFF;
            else
                stride_val = 16'(need + $urandom_range(0, 6));

            write_reg(btga_pkg::CFG_TRANSPOSE, {15'd0, transpose});
            write_reg(btga_pkg::CFG_ROWS, rows_val);
            write_reg(btga_pkg::CFG_COLS, cols_val);
            write_reg(btga_pkg::CFG_ROW_STRIDE, stride_val);
            write_reg(btga_pkg::CFG_TILE_ROWS, trows_val);
            write_reg(btga_pkg::CFG_TILE_COLS, tcols_val);

            if (p % 6 == 2)
                hold_seq++;

            n_items = $urandom_range(25, 55);
            for (int i = 0; i < n_items; i++) begin
                if (i == 0)
                    restart = ($urandom_range(3) != 0);
                else if (walk_finished)
                    restart = 1'($urandom_range(1));
                else
                    restart = ($urandom_range(99) < 3);
                send_item(restart, 1'b0, ADDR_NONE);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/btga_pkg.sv
hdl/btga_cfg.sv
hdl/btga_walker.sv
hdl/btga_addr.sv
hdl/blocked_tile_gather_addresses.sv
test/tb_blocked_tile_gather_addresses.sv
